// ===== rtl/bir_pkg.sv =====
// Shared constants, register codes and helper functions of the bilinear image scaler.
// Used by the scaler top level and the bench; depends on nothing else.

package bir_pkg;

	// Frame store size and weight precision.
	localparam int MAX_SRC_WIDTH  = 128;
	localparam int MAX_SRC_HEIGHT = 128;
	localparam int FRAC_BITS      = 16;
	localparam int POS_FRAC       = 16;

	// Field widths fixed by the interface.
	localparam int COORD_W     = 7;
	localparam int CHAN_W      = 8;
	localparam int NUM_CHAN    = 4;
	localparam int PIX_W       = CHAN_W * NUM_CHAN;
	localparam int STEP_W      = 24;
	localparam int SIZE_REG_W  = 8;
	localparam int COUNT_REG_W = 3;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 24;

	// Source coordinate and size widths.
	localparam int XW     = $clog2(MAX_SRC_WIDTH);
	localparam int YW     = $clog2(MAX_SRC_HEIGHT);
	localparam int XS_W   = $clog2(MAX_SRC_WIDTH + 1);
	localparam int YS_W   = $clog2(MAX_SRC_HEIGHT + 1);
	localparam int PROD_W = COORD_W + STEP_W;
	localparam int XPOS_W = XS_W + POS_FRAC;
	localparam int YPOS_W = YS_W + POS_FRAC;

	// Four banks split by row and column parity.
	localparam int NUM_BANK   = 4;
	localparam int BANK_AW    = (XW - 1) + (YW - 1);
	localparam int BANK_DEPTH = 1 << BANK_AW;

	// Fraction rescaling from the position format to the weight format.
	localparam int UP_SHIFT   = (FRAC_BITS >= POS_FRAC) ? FRAC_BITS - POS_FRAC : 0;
	localparam int DOWN_SHIFT = (FRAC_BITS < POS_FRAC) ? POS_FRAC - FRAC_BITS : 0;
	localparam int SCALE_W    = POS_FRAC + UP_SHIFT;

	// Blend datapath widths.
	localparam int WT_W  = FRAC_BITS + 1;
	localparam int WP_W  = 2 * FRAC_BITS + 1;
	localparam int CP_W  = WP_W + CHAN_W;
	localparam int SUM_W = CP_W + 2;
	localparam int HI_W  = SUM_W - 2 * FRAC_BITS;

	localparam logic [WT_W-1:0]   WT_ONE      = WT_W'(1) << FRAC_BITS;
	localparam logic [WP_W-1:0]   WT_PROD_ONE = WP_W'(1) << (2 * FRAC_BITS);
	localparam logic [CHAN_W-1:0] CHAN_MAX    = '1;

	// Register reset values.
	localparam logic [SIZE_REG_W-1:0]  RST_SOURCE_WIDTH  = SIZE_REG_W'(128);
	localparam logic [SIZE_REG_W-1:0]  RST_SOURCE_HEIGHT = SIZE_REG_W'(128);
	localparam logic [STEP_W-1:0]      RST_STEP          = STEP_W'(65536);
	localparam logic [COUNT_REG_W-1:0] RST_CHANNEL_COUNT = COUNT_REG_W'(4);

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_STEP_X        = 3'd2,
		REG_STEP_Y        = 3'd3,
		REG_CHANNEL_COUNT = 3'd4
	} cfg_reg_t;

	// Operation codes of an input item.
	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_COMPUTE = 1'b1;

	// A zero width acts as one column; a larger width saturates to the store.
	function automatic logic [XS_W-1:0] clamp_width(input logic [SIZE_REG_W-1:0] v);
		logic [XS_W-1:0] r;
		if (v == '0) begin
			r = XS_W'(1);
		end else if (int'(v) > MAX_SRC_WIDTH) begin
			r = XS_W'(MAX_SRC_WIDTH);
		end else begin
			r = XS_W'(v);
		end
		return r;
	endfunction

	// Same rule for the height.
	function automatic logic [YS_W-1:0] clamp_height(input logic [SIZE_REG_W-1:0] v);
		logic [YS_W-1:0] r;
		if (v == '0) begin
			r = YS_W'(1);
		end else if (int'(v) > MAX_SRC_HEIGHT) begin
			r = YS_W'(MAX_SRC_HEIGHT);
		end else begin
			r = YS_W'(v);
		end
		return r;
	endfunction

	// Rescale a position fraction to the weight precision, truncating when narrowing.
	function automatic logic [FRAC_BITS-1:0] frac_scale(input logic [POS_FRAC-1:0] f);
		logic [SCALE_W-1:0] t;
		t = (SCALE_W'(f) << UP_SHIFT) >> DOWN_SHIFT;
		return FRAC_BITS'(t);
	endfunction

	// Channels below the clamped count are active; zero acts as one.
	function automatic logic [NUM_CHAN-1:0] chan_mask(input logic [COUNT_REG_W-1:0] cnt);
		logic [NUM_CHAN-1:0] m;
		int n;
		if (cnt == '0) begin
			n = 1;
		end else if (int'(cnt) > NUM_CHAN) begin
			n = NUM_CHAN;
		end else begin
			n = int'(cnt);
		end
		for (int k = 0; k < NUM_CHAN; k++) begin
			m[k] = (k < n);
		end
		return m;
	endfunction

endpackage

// ===== rtl/bir_ram.sv =====
// Generic simple dual-port RAM: one write port and one read port with registered read data.
// Stand-alone; no package needed.

module bir_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data register holds while no read is issued.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/bilinear_image_resize.sv =====
// Bilinear image scaler top level: frame store banks, coordinate mapping and blend pipeline.
// Depends on bir_pkg and on the generic RAM bir_ram.

// The scaler takes one item per clock unless in_stall holds it off, a source pixel
// write or a destination pixel request, and returns one result per request from its
// stage 6 output register; writes return nothing. The frame store is split into four
// banks by row and column parity so that the four neighbors of a request come out of
// four read ports in the same cycle, which is what sets the rate of one item per clock.
// Writes and reads reach the banks at the same pipeline stage, so a request always sees
// every write transferred before it. There is no clearing pass: a source pixel that was
// never written reads as an undefined value. A stall at the output propagates back
// stage by stage, and empty stages keep filling while the output waits.
// Configuration is accepted in every cycle and must only change while the block is idle.

module bilinear_image_resize import bir_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  op,
	input  logic [COORD_W-1:0]    column,
	input  logic [COORD_W-1:0]    line,
	input  logic [CHAN_W-1:0]     in_chan0,
	input  logic [CHAN_W-1:0]     in_chan1,
	input  logic [CHAN_W-1:0]     in_chan2,
	input  logic [CHAN_W-1:0]     in_chan3,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [COORD_W-1:0]    out_column,
	output logic [COORD_W-1:0]    out_line,
	output logic [CHAN_W-1:0]     out_chan0,
	output logic [CHAN_W-1:0]     out_chan1,
	output logic [CHAN_W-1:0]     out_chan2,
	output logic [CHAN_W-1:0]     out_chan3
);

	// Configuration registers.
	logic [SIZE_REG_W-1:0]  source_width_q;
	logic [SIZE_REG_W-1:0]  source_height_q;
	logic [STEP_W-1:0]      step_x_q;
	logic [STEP_W-1:0]      step_y_q;
	logic [COUNT_REG_W-1:0] channel_count_q;

	// Stage advance and valid bits.
	logic take1, take2, take3, take4, take5, take6;
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;

	// Stage payloads.
	logic                 op_s1, op_s2;
	logic [COORD_W-1:0]   col_s1, col_s2, col_s3, col_s4, col_s5, col_s6;
	logic [COORD_W-1:0]   row_s1, row_s2, row_s3, row_s4, row_s5, row_s6;
	logic [PIX_W-1:0]     pix_s1, pix_s2;
	logic [PROD_W-1:0]    xprod_s2, yprod_s2;
	logic [FRAC_BITS-1:0] fx_s3, fy_s3;
	logic                 x0b_s3, x1b_s3, y0b_s3, y1b_s3;
	logic [WP_W-1:0]      w00_s4, w01_s4, w10_s4, w11_s4;
	logic [PIX_W-1:0]     pix00_s4, pix01_s4, pix10_s4, pix11_s4;
	logic [CP_W-1:0]      prod_s5 [4][NUM_CHAN];
	logic [CHAN_W-1:0]    chan_s6 [NUM_CHAN];

	// Coordinate mapping signals between stage 2 and stage 3.
	logic [XS_W-1:0]     w_eff;
	logic [YS_W-1:0]     h_eff;
	logic [XPOS_W-1:0]   xlim, xpos;
	logic [YPOS_W-1:0]   ylim, ypos;
	logic [XS_W-1:0]     xn;
	logic [YS_W-1:0]     yn;
	logic [POS_FRAC-1:0] xf, yf;
	logic [XW-1:0]       x0, x1;
	logic [YW-1:0]       y0, y1;
	logic [XW-1:0]       xsel [2];
	logic [YW-1:0]       ysel [2];

	// Frame store bank ports.
	logic [XW-1:0]      wcol;
	logic [YW-1:0]      wrow;
	logic               wr_in_range;
	logic               wr_any;
	logic               bank_re;
	logic [NUM_BANK-1:0] bank_we;
	logic [BANK_AW-1:0] bank_waddr;
	logic [BANK_AW-1:0] bank_raddr [NUM_BANK];
	logic [PIX_W-1:0]   bank_rdata [NUM_BANK];

	// Blend signals.
	logic [WT_W-1:0]     wx0, wx1, wy0, wy1;
	logic [NUM_CHAN-1:0] active_mask;
	logic [CHAN_W-1:0]   chan_next [NUM_CHAN];

	// Register writes; indexes past the list are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= RST_SOURCE_WIDTH;
			source_height_q <= RST_SOURCE_HEIGHT;
			step_x_q        <= RST_STEP;
			step_y_q        <= RST_STEP;
			channel_count_q <= RST_CHANNEL_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data[SIZE_REG_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data[SIZE_REG_W-1:0];
				REG_STEP_X:        step_x_q        <= cfg_data[STEP_W-1:0];
				REG_STEP_Y:        step_y_q        <= cfg_data[STEP_W-1:0];
				REG_CHANNEL_COUNT: channel_count_q <= cfg_data[COUNT_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// A stage takes a new item when it is empty or its content moves on.
	assign take6    = !valid_s6 || !out_stall;
	assign take5    = !valid_s5 || take6;
	assign take4    = !valid_s4 || take5;
	assign take3    = !valid_s3 || take4;
	assign take2    = !valid_s2 || take3;
	assign take1    = !valid_s1 || take2;
	assign in_stall = !take1;

	// Valid bits; writes leave the pipeline once they reach the banks.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (take1) valid_s1 <= in_valid;
			if (take2) valid_s2 <= valid_s1;
			if (take3) valid_s3 <= valid_s2 && (op_s2 == OP_COMPUTE);
			if (take4) valid_s4 <= valid_s3;
			if (take5) valid_s5 <= valid_s4;
			if (take6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1 captures the input transfer.
	always_ff @(posedge clk) begin
		if (take1) begin
			op_s1  <= op;
			col_s1 <= column;
			row_s1 <= line;
			pix_s1 <= {in_chan3, in_chan2, in_chan1, in_chan0};
		end
	end

	// Stage 2 scales the destination coordinates by the step ratios.
	always_ff @(posedge clk) begin
		if (take2) begin
			op_s2    <= op_s1;
			col_s2   <= col_s1;
			row_s2   <= row_s1;
			pix_s2   <= pix_s1;
			xprod_s2 <= PROD_W'(col_s1) * PROD_W'(step_x_q);
			yprod_s2 <= PROD_W'(row_s1) * PROD_W'(step_y_q);
		end
	end

	// Clamp the positions to the source size and find near and far neighbors.
	always_comb begin
		w_eff = clamp_width(source_width_q);
		h_eff = clamp_height(source_height_q);
		xlim  = {w_eff, POS_FRAC'(0)};
		ylim  = {h_eff, POS_FRAC'(0)};
		xpos  = (xprod_s2 > PROD_W'(xlim)) ? xlim : XPOS_W'(xprod_s2);
		ypos  = (yprod_s2 > PROD_W'(ylim)) ? ylim : YPOS_W'(yprod_s2);
		xn    = xpos[XPOS_W-1:POS_FRAC];
		yn    = ypos[YPOS_W-1:POS_FRAC];

		// A position on the far edge snaps to the last column or row.
		if (xn >= w_eff) begin
			x0 = XW'(w_eff - XS_W'(1));
			xf = '0;
		end else begin
			x0 = XW'(xn);
			xf = xpos[POS_FRAC-1:0];
		end
		if (yn >= h_eff) begin
			y0 = YW'(h_eff - YS_W'(1));
			yf = '0;
		end else begin
			y0 = YW'(yn);
			yf = ypos[POS_FRAC-1:0];
		end

		// The far neighbor stays on the near one at the last column or row or with a zero fraction.
		x1 = ((xf != '0) && ((XS_W'(x0) + XS_W'(1)) < w_eff)) ? x0 + XW'(1) : x0;
		y1 = ((yf != '0) && ((YS_W'(y0) + YS_W'(1)) < h_eff)) ? y0 + YW'(1) : y0;

		// Each parity bank reads the neighbor column and row of its own parity.
		xsel[0] = x0[0] ? x1 : x0;
		xsel[1] = x0[0] ? x0 : x1;
		ysel[0] = y0[0] ? y1 : y0;
		ysel[1] = y0[0] ? y0 : y1;
	end

	// Source pixel writes go to the bank of their row and column parity.
	assign wcol        = XW'(col_s2);
	assign wrow        = YW'(row_s2);
	assign wr_in_range = (int'(col_s2) < MAX_SRC_WIDTH) && (int'(row_s2) < MAX_SRC_HEIGHT);
	assign wr_any      = take3 && valid_s2 && (op_s2 == OP_WRITE) && wr_in_range;
	assign bank_re     = take3 && valid_s2 && (op_s2 == OP_COMPUTE);
	assign bank_waddr  = {wrow[YW-1:1], wcol[XW-1:1]};

	for (genvar b = 0; b < NUM_BANK; b++) begin : g_bank
		assign bank_we[b]    = wr_any && ({wrow[0], wcol[0]} == 2'(b));
		assign bank_raddr[b] = {ysel[b / 2][YW-1:1], xsel[b % 2][XW-1:1]};

		bir_ram #(
			.WIDTH (PIX_W),
			.DEPTH (BANK_DEPTH)
		) u_bank (
			.clk   (clk),
			.we    (bank_we[b]),
			.waddr (bank_waddr),
			.wdata (pix_s2),
			.re    (bank_re),
			.raddr (bank_raddr[b]),
			.rdata (bank_rdata[b])
		);
	end

	// Stage 3 keeps the weights and neighbor parities next to the bank read data.
	always_ff @(posedge clk) begin
		if (take3) begin
			col_s3 <= col_s2;
			row_s3 <= row_s2;
			fx_s3  <= frac_scale(xf);
			fy_s3  <= frac_scale(yf);
			x0b_s3 <= x0[0];
			x1b_s3 <= x1[0];
			y0b_s3 <= y0[0];
			y1b_s3 <= y1[0];
		end
	end

	// Stage 4 forms the four area weights and routes the banks to the neighbors.
	assign wx1 = WT_W'(fx_s3);
	assign wy1 = WT_W'(fy_s3);
	assign wx0 = WT_ONE - wx1;
	assign wy0 = WT_ONE - wy1;

	always_ff @(posedge clk) begin
		if (take4) begin
			col_s4   <= col_s3;
			row_s4   <= row_s3;
			w00_s4   <= WP_W'(wx0) * WP_W'(wy0);
			w01_s4   <= WP_W'(wx1) * WP_W'(wy0);
			w10_s4   <= WP_W'(wx0) * WP_W'(wy1);
			w11_s4   <= WP_W'(wx1) * WP_W'(wy1);
			pix00_s4 <= bank_rdata[{y0b_s3, x0b_s3}];
			pix01_s4 <= bank_rdata[{y0b_s3, x1b_s3}];
			pix10_s4 <= bank_rdata[{y1b_s3, x0b_s3}];
			pix11_s4 <= bank_rdata[{y1b_s3, x1b_s3}];
		end
	end

	// Stage 5 weights every channel of every neighbor.
	always_ff @(posedge clk) begin
		if (take5) begin
			col_s5 <= col_s4;
			row_s5 <= row_s4;
			for (int k = 0; k < NUM_CHAN; k++) begin
				prod_s5[0][k] <= CP_W'(w00_s4) * CP_W'(pix00_s4[CHAN_W*k +: CHAN_W]);
				prod_s5[1][k] <= CP_W'(w01_s4) * CP_W'(pix01_s4[CHAN_W*k +: CHAN_W]);
				prod_s5[2][k] <= CP_W'(w10_s4) * CP_W'(pix10_s4[CHAN_W*k +: CHAN_W]);
				prod_s5[3][k] <= CP_W'(w11_s4) * CP_W'(pix11_s4[CHAN_W*k +: CHAN_W]);
			end
		end
	end

	// Sum the weighted neighbors, drop the fraction, saturate and blank unused channels.
	always_comb begin
		logic [SUM_W-1:0] sum;
		logic [HI_W-1:0]  hi;
		active_mask = chan_mask(channel_count_q);
		for (int k = 0; k < NUM_CHAN; k++) begin
			sum = SUM_W'(prod_s5[0][k]) + SUM_W'(prod_s5[1][k])
			    + SUM_W'(prod_s5[2][k]) + SUM_W'(prod_s5[3][k]);
			hi  = sum[SUM_W-1:2*FRAC_BITS];
			if (!active_mask[k]) begin
				chan_next[k] = '0;
			end else if (hi > HI_W'(CHAN_MAX)) begin
				chan_next[k] = CHAN_MAX;
			end else begin
				chan_next[k] = hi[CHAN_W-1:0];
			end
		end
	end

	// Stage 6 is the output register.
	always_ff @(posedge clk) begin
		if (take6) begin
			col_s6 <= col_s5;
			row_s6 <= row_s5;
			for (int k = 0; k < NUM_CHAN; k++) begin
				chan_s6[k] <= chan_next[k];
			end
		end
	end

	assign out_valid  = valid_s6;
	assign out_column = col_s6;
	assign out_line   = row_s6;
	assign out_chan0  = chan_s6[0];
	assign out_chan1  = chan_s6[1];
	assign out_chan2  = chan_s6[2];
	assign out_chan3  = chan_s6[3];

	// The input only stalls when every stage holds an item and the output is stalled.
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3 && valid_s4 && valid_s5
			&& valid_s6 && out_stall))
		else $error("input stalled while the pipeline has a free stage");

	// A bank cycle is either a write or a read, never both.
	a_bank_rw_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!((bank_we != '0) && bank_re))
		else $error("frame store write and read issued in the same cycle");

	// The four area weights always add up to exactly one.
	a_weight_sum: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s4 |-> ((SUM_W'(w00_s4) + SUM_W'(w01_s4) + SUM_W'(w10_s4) + SUM_W'(w11_s4))
			== SUM_W'(WT_PROD_ONE)))
		else $error("bilinear weights do not sum to one");

	// A new result only appears after a request left the last blend stage.
	a_out_from_blend: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(valid_s5))
		else $error("output became valid without a request in the blend stage");

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the bilinear image scaler: frame store writes, pixel requests, registers.
// Depends on bir_pkg and the bilinear_image_resize top level; everything else is local.

`timescale 1ns / 100ps

module tb import bir_pkg::*; ();

	localparam int RESET_CYCLES   = 9;
	localparam int DRAIN_CYCLES   = 12;
	localparam int END_CYCLES     = 20;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 45;
	localparam int HOLD_PHASE     = 1;
	localparam int HOLD_AT        = 5;
	// Corner of the source frame that random phases keep fully written.
	localparam int FILL_SPAN      = 9;
	// With a wide source this step keeps every neighbor inside the written corner.
	localparam logic [STEP_W-1:0] NARROW_STEP_MAX = STEP_W'('h1000);
	localparam logic [CFG_IDX_W-1:0] REG_PAST_LIST_FIRST = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_PAST_LIST_LAST  = CFG_IDX_W'(7);

	typedef enum bit {ROW_ITEM, ROW_REG} row_kind_t;

	typedef struct packed {
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] line;
		logic [PIX_W-1:0]   chans;
	} dest_pixel_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] data;
		logic                  op;
		logic [COORD_W-1:0]    column;
		logic [COORD_W-1:0]    line;
		logic [PIX_W-1:0]      pix;
		bit                    typed;
		logic [PIX_W-1:0]      want;
	} script_row_t;

	// Clock, reset and block ports.
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = OP_WRITE;
	logic [COORD_W-1:0] column = '0;
	logic [COORD_W-1:0] line = '0;
	logic [CHAN_W-1:0] in_chan0 = '0;
	logic [CHAN_W-1:0] in_chan1 = '0;
	logic [CHAN_W-1:0] in_chan2 = '0;
	logic [CHAN_W-1:0] in_chan3 = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [COORD_W-1:0] out_column;
	logic [COORD_W-1:0] out_line;
	logic [CHAN_W-1:0] out_chan0;
	logic [CHAN_W-1:0] out_chan1;
	logic [CHAN_W-1:0] out_chan2;
	logic [CHAN_W-1:0] out_chan3;

	// Local copy of the register file and the source frame.
	logic [SIZE_REG_W-1:0]  reg_width  = RST_SOURCE_WIDTH;
	logic [SIZE_REG_W-1:0]  reg_height = RST_SOURCE_HEIGHT;
	logic [STEP_W-1:0]      reg_step_x = RST_STEP;
	logic [STEP_W-1:0]      reg_step_y = RST_STEP;
	logic [COUNT_REG_W-1:0] reg_count  = RST_CHANNEL_COUNT;
	logic [PIX_W-1:0] src_frame [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];
	bit src_written [MAX_SRC_WIDTH*MAX_SRC_HEIGHT];

	dest_pixel_t pending_pixels [$];
	dest_pixel_t got_pixel, want_pixel;

	int errors = 0;
	int n_writes = 0;
	int n_requests = 0;
	int n_reg_writes = 0;
	int n_checked = 0;
	int n_in_held = 0;
	int quiet_cycles = 0;
	int burst_left = 0;
	bit hold_req = 1'b0;

	always #4 clk = ~clk;

	bilinear_image_resize DUT (.*);

	// A size register of zero acts as one; anything past the store saturates.
	function automatic int eff_size(input logic [SIZE_REG_W-1:0] v, input int maxv);
		if (v == '0) begin
			return 1;
		end
		return (int'(v) > maxv) ? maxv : int'(v);
	endfunction

	// Map a destination index onto the near and far source index and the far weight.
	function automatic void map_axis(input logic [COORD_W-1:0] idx, input logic [STEP_W-1:0] step,
			input int size, output int near, output int far, output bit [63:0] wt);
		bit [63:0] pos;
		bit [63:0] lim;
		int n;
		int f;
		pos = 64'(idx) * 64'(step);
		lim = 64'(size) << POS_FRAC;
		if (pos > lim) begin
			pos = lim;
		end
		n = int'(pos >> POS_FRAC);
		f = int'(pos & ((64'd1 << POS_FRAC) - 64'd1));
		// At the right or bottom edge the position snaps to the last sample.
		if (n > size - 1) begin
			n = size - 1;
			f = 0;
		end
		near = n;
		far = (f != 0) ? n + 1 : n;
		if (far > size - 1) begin
			far = n;
		end
		if (FRAC_BITS >= POS_FRAC) begin
			wt = 64'(f) << (FRAC_BITS - POS_FRAC);
		end else begin
			wt = 64'(f) >> (POS_FRAC - FRAC_BITS);
		end
	endfunction

	// True when all four neighbors of a request hold written data.
	function automatic bit reads_written(input logic [COORD_W-1:0] c, input logic [COORD_W-1:0] l);
		int x0, x1, y0, y1;
		bit [63:0] fx, fy;
		map_axis(c, reg_step_x, eff_size(reg_width, MAX_SRC_WIDTH), x0, x1, fx);
		map_axis(l, reg_step_y, eff_size(reg_height, MAX_SRC_HEIGHT), y0, y1, fy);
		return src_written[y0*MAX_SRC_WIDTH + x0] && src_written[y0*MAX_SRC_WIDTH + x1]
			&& src_written[y1*MAX_SRC_WIDTH + x0] && src_written[y1*MAX_SRC_WIDTH + x1];
	endfunction

	// Blend the four neighbors of a destination pixel with the current settings.
	function automatic logic [PIX_W-1:0] blend_pixel(input logic [COORD_W-1:0] c,
			input logic [COORD_W-1:0] l);
		int x0, x1, y0, y1, nch;
		bit [63:0] fx, fy, one, acc;
		logic [PIX_W-1:0] p00, p01, p10, p11, res;
		nch = (reg_count == '0) ? 1 : ((int'(reg_count) > NUM_CHAN) ? NUM_CHAN : int'(reg_count));
		map_axis(c, reg_step_x, eff_size(reg_width, MAX_SRC_WIDTH), x0, x1, fx);
		map_axis(l, reg_step_y, eff_size(reg_height, MAX_SRC_HEIGHT), y0, y1, fy);
		one = 64'd1 << FRAC_BITS;
		p00 = src_frame[y0*MAX_SRC_WIDTH + x0];
		p01 = src_frame[y0*MAX_SRC_WIDTH + x1];
		p10 = src_frame[y1*MAX_SRC_WIDTH + x0];
		p11 = src_frame[y1*MAX_SRC_WIDTH + x1];
		res = '0;
		for (int k = 0; k < NUM_CHAN; k++) begin
			if (k < nch) begin
				acc = (one - fx) * (one - fy) * 64'(p00[CHAN_W*k +: CHAN_W])
					+ fx * (one - fy) * 64'(p01[CHAN_W*k +: CHAN_W])
					+ (one - fx) * fy * 64'(p10[CHAN_W*k +: CHAN_W])
					+ fx * fy * 64'(p11[CHAN_W*k +: CHAN_W]);
				acc = acc >> (2 * FRAC_BITS);
				if (acc > 64'(CHAN_MAX)) begin
					acc = 64'(CHAN_MAX);
				end
				res[CHAN_W*k +: CHAN_W] = acc[CHAN_W-1:0];
			end
		end
		return res;
	endfunction

	function automatic script_row_t item_row(input logic o, input logic [COORD_W-1:0] c,
			input logic [COORD_W-1:0] l, input logic [PIX_W-1:0] pix, input bit typed,
			input logic [PIX_W-1:0] want);
		script_row_t r;
		r.kind = ROW_ITEM;
		r.idx = '0;
		r.data = '0;
		r.op = o;
		r.column = c;
		r.line = l;
		r.pix = pix;
		r.typed = typed;
		r.want = want;
		return r;
	endfunction

	function automatic script_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		script_row_t r;
		r = item_row(OP_WRITE, '0, '0, '0, 1'b0, '0);
		r.kind = ROW_REG;
		r.idx = idx;
		r.data = data;
		return r;
	endfunction

	// Mostly small sizes, now and then zero or values past the store.
	function automatic logic [SIZE_REG_W-1:0] rand_size_reg();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return SIZE_REG_W'(MAX_SRC_WIDTH);
			2: return SIZE_REG_W'($urandom_range(MAX_SRC_WIDTH + 1, 255));
			3: return SIZE_REG_W'($urandom_range(9, 16));
			default: return SIZE_REG_W'($urandom_range(1, 8));
		endcase
	endfunction

	function automatic logic [STEP_W-1:0] rand_step(input int size);
		if (size > FILL_SPAN) begin
			return STEP_W'($urandom_range(0, NARROW_STEP_MAX));
		end
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return RST_STEP;
			3: return STEP_W'($urandom_range(0, 'hFFFF));
			4: return STEP_W'($urandom());
			default: return STEP_W'($urandom_range(0, 'h30000));
		endcase
	endfunction

	// Offer one item in the sender's burst pattern and record what it should produce.
	task automatic send_item(input logic o, input logic [COORD_W-1:0] c,
			input logic [COORD_W-1:0] l, input logic [PIX_W-1:0] pix, input bit typed,
			input logic [PIX_W-1:0] want);
		int gap;
		dest_pixel_t e;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 24);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		in_valid <= 1'b1;
		op <= o;
		column <= c;
		line <= l;
		{in_chan3, in_chan2, in_chan1, in_chan0} <= pix;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (o == OP_WRITE) begin
			src_frame[int'(l)*MAX_SRC_WIDTH + int'(c)] = pix;
			src_written[int'(l)*MAX_SRC_WIDTH + int'(c)] = 1'b1;
			n_writes++;
		end else begin
			e.column = c;
			e.line = l;
			e.chans = typed ? want : blend_pixel(c, l);
			pending_pixels.push_back(e);
			n_requests++;
		end
	endtask

	// Stop offering, let every result arrive, then give the pipeline time to empty.
	task automatic quiesce();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// One register transfer; the local copy changes once the block has taken it.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_SOURCE_WIDTH: reg_width = data[SIZE_REG_W-1:0];
			REG_SOURCE_HEIGHT: reg_height = data[SIZE_REG_W-1:0];
			REG_STEP_X: reg_step_x = data[STEP_W-1:0];
			REG_STEP_Y: reg_step_y = data[STEP_W-1:0];
			REG_CHANNEL_COUNT: reg_count = data[COUNT_REG_W-1:0];
			default: ;
		endcase
		n_reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Receiver: stretches of varying stall density, and one long hold-off on request.
	initial begin : receiver
		int pct;
		int left;
		pct = 0;
		left = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				if (left == 0) begin
					left = $urandom_range(8, 60);
					case ($urandom_range(0, 3))
						0: pct = 0;
						1: pct = 20;
						2: pct = 50;
						default: pct = 85;
					endcase
				end
				left--;
				out_stall <= ($urandom_range(0, 99) < pct);
			end
		end
	end

	// Compare each result transfer with the oldest pending pixel.
	always @(posedge clk) begin
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			got_pixel.column = out_column;
			got_pixel.line = out_line;
			got_pixel.chans = {out_chan3, out_chan2, out_chan1, out_chan0};
			if (pending_pixels.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, expected none, got %h", $time, got_pixel);
			end else begin
				want_pixel = pending_pixels.pop_front();
				n_checked++;
				if (got_pixel.column !== want_pixel.column) begin
					errors++;
					$display("%0t: out_column expected %0d got %0d", $time,
						want_pixel.column, got_pixel.column);
				end
				if (got_pixel.line !== want_pixel.line) begin
					errors++;
					$display("%0t: out_line expected %0d got %0d", $time,
						want_pixel.line, got_pixel.line);
				end
				for (int k = 0; k < NUM_CHAN; k++) begin
					if (got_pixel.chans[CHAN_W*k +: CHAN_W] !== want_pixel.chans[CHAN_W*k +: CHAN_W]) begin
						errors++;
						$display("%0t: out_chan%0d at (%0d,%0d) expected %h got %h", $time, k,
							want_pixel.column, want_pixel.line,
							want_pixel.chans[CHAN_W*k +: CHAN_W], got_pixel.chans[CHAN_W*k +: CHAN_W]);
					end
				end
			end
		end
	end

	// Watchdog on cycles without any transfer; also counts input back-pressure.
	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)
				|| (cfg_valid && cfg_ready === 1'b1)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (in_valid && in_stall === 1'b1) begin
			n_in_held++;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding", $time,
				quiet_cycles, pending_pixels.size());
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		script_row_t script [$];
		script_row_t r;
		logic [SIZE_REG_W-1:0] w_reg, h_reg;
		logic [COORD_W-1:0] c, l;
		logic o;
		int span_x, span_y;
		bit found;

		// Directed rows: reset settings first, then edge and out-of-range settings.
		script.push_back(item_row(OP_WRITE, 7'd0, 7'd0, 32'hFFFF_FFFF, 1'b0, '0));
		script.push_back(item_row(OP_WRITE, 7'd127, 7'd127, 32'h0000_0000, 1'b0, '0));
		script.push_back(item_row(OP_WRITE, 7'd1, 7'd0, 32'h1122_3344, 1'b0, '0));
		script.push_back(item_row(OP_WRITE, 7'd0, 7'd1, 32'h8080_8080, 1'b0, '0));
		script.push_back(item_row(OP_WRITE, 7'd1, 7'd1, 32'h7F7F_7F7F, 1'b0, '0));
		script.push_back(item_row(OP_WRITE, 7'd0, 7'd127, 32'h0102_0304, 1'b0, '0));
		script.push_back(item_row(OP_WRITE, 7'd127, 7'd0, 32'h5AA5_C33C, 1'b0, '0));
		script.push_back(item_row(OP_COMPUTE, 7'd0, 7'd0, 32'h0, 1'b1, 32'hFFFF_FFFF));
		script.push_back(item_row(OP_COMPUTE, 7'd127, 7'd127, 32'hFFFF_FFFF, 1'b1, 32'h0));
		script.push_back(item_row(OP_COMPUTE, 7'd1, 7'd1, 32'h0, 1'b1, 32'h7F7F_7F7F));
		script.push_back(item_row(OP_COMPUTE, 7'd127, 7'd0, 32'h0, 1'b1, 32'h5AA5_C33C));
		// Half steps on a 2x2 source: true blends and the clamped far neighbor.
		script.push_back(reg_row(REG_SOURCE_WIDTH, 24'd2));
		script.push_back(reg_row(REG_SOURCE_HEIGHT, 24'd2));
		script.push_back(reg_row(REG_STEP_X, 24'h00_8000));
		script.push_back(reg_row(REG_STEP_Y, 24'h00_8000));
		script.push_back(item_row(OP_COMPUTE, 7'd1, 7'd1, 32'h0, 1'b0, '0));
		script.push_back(item_row(OP_COMPUTE, 7'd3, 7'd3, 32'h0, 1'b0, '0));
		script.push_back(item_row(OP_COMPUTE, 7'd127, 7'd127, 32'h0, 1'b0, '0));
		// Largest step snaps to the edge, zero step stays at the origin, one channel only.
		script.push_back(reg_row(REG_STEP_X, 24'hFF_FFFF));
		script.push_back(reg_row(REG_STEP_Y, 24'h00_0000));
		script.push_back(reg_row(REG_CHANNEL_COUNT, 24'd0));
		script.push_back(item_row(OP_COMPUTE, 7'd127, 7'd0, 32'h0, 1'b1, 32'h0000_0044));
		script.push_back(item_row(OP_COMPUTE, 7'd0, 7'd127, 32'h0, 1'b1, 32'h0000_00FF));
		// Zero width, height past the store, count past four, writes to unused indexes.
		script.push_back(reg_row(REG_SOURCE_WIDTH, 24'd0));
		script.push_back(reg_row(REG_SOURCE_HEIGHT, 24'd255));
		script.push_back(reg_row(REG_STEP_X, 24'h01_0000));
		script.push_back(reg_row(REG_STEP_Y, 24'h01_0000));
		script.push_back(reg_row(REG_CHANNEL_COUNT, 24'd7));
		script.push_back(reg_row(REG_PAST_LIST_FIRST, 24'd0));
		script.push_back(reg_row(REG_PAST_LIST_LAST, 24'hFF_FFFF));
		script.push_back(item_row(OP_COMPUTE, 7'd5, 7'd127, 32'h0, 1'b1, 32'h0102_0304));
		script.push_back(item_row(OP_COMPUTE, 7'd127, 7'd0, 32'h0, 1'b1, 32'hFFFF_FFFF));
		// Largest fraction: weights just short of one.
		script.push_back(reg_row(REG_SOURCE_WIDTH, 24'd2));
		script.push_back(reg_row(REG_SOURCE_HEIGHT, 24'd2));
		script.push_back(reg_row(REG_STEP_X, 24'h00_FFFF));
		script.push_back(reg_row(REG_STEP_Y, 24'h00_FFFF));
		script.push_back(reg_row(REG_CHANNEL_COUNT, 24'd4));
		script.push_back(item_row(OP_COMPUTE, 7'd1, 7'd1, 32'h0, 1'b0, '0));
		script.push_back(item_row(OP_COMPUTE, 7'd1, 7'd0, 32'h0, 1'b0, '0));
		script.push_back(item_row(OP_COMPUTE, 7'd0, 7'd1, 32'h0, 1'b0, '0));

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		foreach (script[i]) begin
			r = script[i];
			if (r.kind == ROW_REG) begin
				quiesce();
				write_reg(r.idx, r.data);
			end else begin
				send_item(r.op, r.column, r.line, r.pix, r.typed, r.want);
			end
		end

		// Random phases: new settings, fill the source corner, then mixed traffic.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			quiesce();
			w_reg = rand_size_reg();
			h_reg = rand_size_reg();
			write_reg(REG_SOURCE_WIDTH, {16'($urandom()), w_reg});
			write_reg(REG_SOURCE_HEIGHT, {16'($urandom()), h_reg});
			write_reg(REG_STEP_X, rand_step(eff_size(w_reg, MAX_SRC_WIDTH)));
			write_reg(REG_STEP_Y, rand_step(eff_size(h_reg, MAX_SRC_HEIGHT)));
			write_reg(REG_CHANNEL_COUNT, {21'($urandom()), COUNT_REG_W'($urandom_range(0, 7))});
			if ($urandom_range(0, 3) == 0) begin
				write_reg(CFG_IDX_W'($urandom_range(REG_PAST_LIST_FIRST, REG_PAST_LIST_LAST)),
					CFG_DATA_W'($urandom()));
			end
			span_x = eff_size(w_reg, MAX_SRC_WIDTH);
			span_y = eff_size(h_reg, MAX_SRC_HEIGHT);
			if (span_x > FILL_SPAN) begin
				span_x = FILL_SPAN;
			end
			if (span_y > FILL_SPAN) begin
				span_y = FILL_SPAN;
			end
			for (int y = 0; y < span_y; y++) begin
				for (int x = 0; x < span_x; x++) begin
					if (!src_written[y*MAX_SRC_WIDTH + x]) begin
						send_item(OP_WRITE, COORD_W'(x), COORD_W'(y), PIX_W'($urandom()), 1'b0, '0);
					end
				end
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == HOLD_PHASE && n == HOLD_AT) begin
					hold_req = 1'b1;
				end
				found = 1'b0;
				if ($urandom_range(0, 9) >= 3) begin
					for (int t = 0; t < 20 && !found; t++) begin
						c = $urandom_range(0, 1) ? COORD_W'($urandom()) : COORD_W'($urandom_range(0, 15));
						l = $urandom_range(0, 1) ? COORD_W'($urandom()) : COORD_W'($urandom_range(0, 15));
						found = reads_written(c, l);
					end
				end
				if (found) begin
					o = OP_COMPUTE;
				end else begin
					o = OP_WRITE;
					// A third of the writes land anywhere in the store.
					if ($urandom_range(0, 2) == 0) begin
						c = COORD_W'($urandom());
						l = COORD_W'($urandom());
					end else begin
						c = COORD_W'($urandom_range(0, span_x - 1));
						l = COORD_W'($urandom_range(0, span_y - 1));
					end
				end
				send_item(o, c, l, PIX_W'($urandom()), 1'b0, '0);
			end
		end

		quiesce();
		repeat (END_CYCLES) @(posedge clk);
		$display("Covered %0d source writes and %0d pixel requests (%0d results checked).",
			n_writes, n_requests, n_checked);
		$display("%0d register writes; input held back by the block for %0d cycles.",
			n_reg_writes, n_in_held);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/bir_pkg.sv
rtl/bir_ram.sv
rtl/bilinear_image_resize.sv
bench/tb.sv
